// File: design/dtfp_pkg.sv
package dtfp_pkg;

	// default sizes of the fixed-point result
	localparam int DEF_INT_BITS  = 16;
	localparam int DEF_FRAC_BITS = 32;

	// extra fraction bits kept while accumulating, dropped at the end
	localparam int GUARD_BITS = 8;

	// range limit register
	localparam int                  RANGE_W     = 16;
	localparam logic [RANGE_W-1:0]  RANGE_RESET = 16'd2;

	// fraction weight table: entry k holds floor(2^(frac+guard) / 10^(k+1))
	localparam int WT_DEPTH = 14;
	localparam int CNT_W    = $clog2(WT_DEPTH);

	// character codes
	localparam logic [7:0] CH_TAB   = 8'd9;
	localparam logic [7:0] CH_CR    = 8'd13;
	localparam logic [7:0] CH_SPACE = 8'd32;
	localparam logic [7:0] CH_PLUS  = 8'd43;
	localparam logic [7:0] CH_MINUS = 8'd45;
	localparam logic [7:0] CH_DOT   = 8'd46;
	localparam logic [7:0] CH_ZERO  = 8'd48;
	localparam logic [7:0] CH_NINE  = 8'd57;

	// result flags in tuser, lowest bit first
	localparam int TU_VALID   = 0;
	localparam int TU_INRANGE = 1;
	localparam int TU_SAT     = 2;
	localparam int TUSER_W    = 3;

	typedef enum logic [3:0] {
		PH_WS   = 4'b0001,
		PH_INT  = 4'b0010,
		PH_FRAC = 4'b0100,
		PH_STOP = 4'b1000
	} phase_t;

	// elaboration-time weight of the fraction digit at position k
	function automatic logic [63:0] frac_weight(input int fb, input int k);
		logic [63:0] w;
		w = 64'd1 << (fb + GUARD_BITS);
		for (int i = 0; i <= k; i++) begin
			w = w / 64'd10;
		end
		return w;
	endfunction

endpackage

// File: design/decimal_text_to_fixed_point.sv
// Decimal text to fixed-point converter. Characters of a decimal number come in one per
// input transaction on s_axis (tdata = character code, tlast on the final character);
// each string gives one output transaction on m_axis carrying the signed value in
// two's complement with FRAC_BITS fraction bits, plus tuser flags: strict syntax ok,
// magnitude within range_limit, and integer overflow (the integer part is then clamped
// to all ones). Leading whitespace is skipped by the parser but fails the syntax check;
// parsing stops at the first character that does not fit. One character is taken every
// clock cycle, with no gap between strings: the per-character update of the parse
// state is a single registered step, a multiply-by-ten add on the integer part and a
// digit-times-weight add on the fraction, the weights coming from a constant table.
// The result reaches m_axis through registers in order: the accepted character loads the
// input register, the finished string moves to the string snapshot, and from there to the
// output register. A stalled m_axis only stops the input when a final character sits in
// the input register while the snapshot and the output register both still hold results
// that have not been taken. range_limit is written through cfg_wr_en / cfg_wr_data;
// the user must do so only between strings, which the block itself does not enforce.
module decimal_text_to_fixed_point #(
	parameter int INT_BITS  = dtfp_pkg::DEF_INT_BITS,
	parameter int FRAC_BITS = dtfp_pkg::DEF_FRAC_BITS,
	localparam int VALUE_W  = INT_BITS + FRAC_BITS + 1,
	localparam int DATA_W   = ((VALUE_W + 7) / 8) * 8
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration: range_limit
	input  logic                          cfg_wr_en,
	input  logic [dtfp_pkg::RANGE_W-1:0]  cfg_wr_data,
	// characters in
	input  logic                          s_axis_tvalid,
	output logic                          s_axis_tready,
	input  logic [7:0]                    s_axis_tdata,  // char_code
	input  logic                          s_axis_tlast,  // last_char
	// results out
	output logic                          m_axis_tvalid,
	input  logic                          m_axis_tready,
	output logic [DATA_W-1:0]             m_axis_tdata,  // value, zero padded
	output logic [dtfp_pkg::TUSER_W-1:0]  m_axis_tuser   // valid_res, within_range, saturated
);
	import dtfp_pkg::*;

	localparam int WW = FRAC_BITS + GUARD_BITS;  // fraction accumulator width
	localparam int MW = INT_BITS + FRAC_BITS;    // magnitude width
	localparam int CW = (INT_BITS > RANGE_W) ? INT_BITS : RANGE_W;
	localparam logic [INT_BITS-1:0] INT_MAX = {INT_BITS{1'b1}};

	// fraction weights, constant table
	logic [WW-1:0] wt_tab [WT_DEPTH];
	for (genvar g = 0; g < WT_DEPTH; g++) begin : g_wt
		assign wt_tab[g] = WW'(frac_weight(FRAC_BITS, g));
	end

	// configuration register
	logic [RANGE_W-1:0] range_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			range_q <= RANGE_RESET;
		end else if (cfg_wr_en) begin
			range_q <= cfg_wr_data;
		end
	end

	// handshake and stage control
	logic          s1_valid_s1;
	logic [7:0]    char_s1;
	logic          last_s1;
	logic          s2_valid_s2;
	logic          out_valid_q;
	logic          out_free;
	logic          s2_free;
	logic          s1_go;
	logic          s2_go;

	assign out_free      = !out_valid_q || m_axis_tready;
	assign s2_free       = !s2_valid_s2 || out_free;
	assign s2_go         = s2_valid_s2 && out_free;
	// only a final character needs room in the result stage
	assign s1_go         = s1_valid_s1 && (!last_s1 || s2_free);
	assign s_axis_tready = !s1_valid_s1 || s1_go;

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			s1_valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tvalid && s_axis_tready) begin
			char_s1 <= s_axis_tdata;
			last_s1 <= s_axis_tlast;
		end
	end

	// parse state of the current string
	phase_t             phase_q;
	logic               neg_q;
	logic [INT_BITS-1:0] int_q;
	logic [WW-1:0]      frac_q;
	logic [CNT_W-1:0]   fcnt_q;
	logic               first_q;
	logic               dot_q;
	logic               dig_q;
	logic               bad_q;
	logic               ovf_q;

	// updated state after the character in the input register
	phase_t             phase_u;
	logic               neg_u;
	logic [INT_BITS-1:0] int_u;
	logic [WW-1:0]      frac_u;
	logic [CNT_W-1:0]   fcnt_u;
	logic               dot_u;
	logic               dig_u;
	logic               bad_u;
	logic               ovf_u;

	logic               is_digit;
	logic               is_space;
	logic               is_sign;
	logic [3:0]         digit;
	logic [INT_BITS+3:0] int_ext;
	logic [INT_BITS+3:0] int_add;
	logic               int_big;
	logic [INT_BITS-1:0] int_sat;
	logic [WW+3:0]      frac_prod;
	logic [WW+3:0]      frac_add;
	logic [WW-1:0]      wt;

	assign is_digit = char_s1 inside {[CH_ZERO:CH_NINE]};
	assign is_space = char_s1 inside {CH_SPACE, [CH_TAB:CH_CR]};
	assign is_sign  = char_s1 inside {CH_PLUS, CH_MINUS};
	assign digit    = 4'(char_s1 - CH_ZERO);

	// integer digit: acc * 10 + d, clamped
	assign int_ext = (INT_BITS+4)'(int_q);
	assign int_add = (int_ext << 3) + (int_ext << 1) + (INT_BITS+4)'(digit);
	assign int_big = int_add > (INT_BITS+4)'(INT_MAX);
	assign int_sat = int_big ? INT_MAX : int_add[INT_BITS-1:0];

	// fraction digit: acc + d * weight
	assign wt = wt_tab[fcnt_q];

	always_comb begin
		frac_prod = '0;
		for (int i = 0; i < 4; i++) begin
			if (digit[i]) begin
				frac_prod = frac_prod + ((WW+4)'(wt) << i);
			end
		end
		frac_add = (WW+4)'(frac_q) + frac_prod;
	end

	always_comb begin
		phase_u = phase_q;
		neg_u   = neg_q;
		int_u   = int_q;
		frac_u  = frac_q;
		fcnt_u  = fcnt_q;
		dot_u   = dot_q;
		dig_u   = dig_q;
		bad_u   = bad_q;
		ovf_u   = ovf_q;

		// strict syntax check
		if (!(first_q && is_sign)) begin
			if (char_s1 == CH_DOT) begin
				bad_u = bad_q || dot_q;
				dot_u = 1'b1;
			end else if (is_digit) begin
				dig_u = 1'b1;
			end else begin
				bad_u = 1'b1;
			end
		end

		// lenient parse
		case (phase_q)
			PH_WS: begin
				if (is_space) begin
					phase_u = PH_WS;
				end else if (is_sign) begin
					neg_u   = (char_s1 == CH_MINUS);
					phase_u = PH_INT;
				end else if (is_digit) begin
					int_u   = int_sat;
					ovf_u   = ovf_q || int_big;
					phase_u = PH_INT;
				end else if (char_s1 == CH_DOT) begin
					phase_u = PH_FRAC;
				end else begin
					phase_u = PH_STOP;
				end
			end
			PH_INT: begin
				if (is_digit) begin
					int_u = int_sat;
					ovf_u = ovf_q || int_big;
				end else if (char_s1 == CH_DOT) begin
					phase_u = PH_FRAC;
				end else begin
					phase_u = PH_STOP;
				end
			end
			PH_FRAC: begin
				if (is_digit) begin
					frac_u = frac_add[WW-1:0];
					// digits past the table end reuse its last weight
					if (fcnt_q != CNT_W'(WT_DEPTH - 1)) begin
						fcnt_u = fcnt_q + CNT_W'(1);
					end
				end else begin
					phase_u = PH_STOP;
				end
			end
			default: begin
				phase_u = PH_STOP;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_WS;
			neg_q   <= 1'b0;
			int_q   <= '0;
			frac_q  <= '0;
			fcnt_q  <= '0;
			first_q <= 1'b1;
			dot_q   <= 1'b0;
			dig_q   <= 1'b0;
			bad_q   <= 1'b0;
			ovf_q   <= 1'b0;
		end else if (s1_go) begin
			if (last_s1) begin
				// string done, start over
				phase_q <= PH_WS;
				neg_q   <= 1'b0;
				int_q   <= '0;
				frac_q  <= '0;
				fcnt_q  <= '0;
				first_q <= 1'b1;
				dot_q   <= 1'b0;
				dig_q   <= 1'b0;
				bad_q   <= 1'b0;
				ovf_q   <= 1'b0;
			end else begin
				phase_q <= phase_u;
				neg_q   <= neg_u;
				int_q   <= int_u;
				frac_q  <= frac_u;
				fcnt_q  <= fcnt_u;
				first_q <= 1'b0;
				dot_q   <= dot_u;
				dig_q   <= dig_u;
				bad_q   <= bad_u;
				ovf_q   <= ovf_u;
			end
		end
	end

	// finished string snapshot
	logic [INT_BITS-1:0]  int_s2;
	logic [FRAC_BITS-1:0] frac_s2;
	logic                 neg_s2;
	logic                 ok_s2;
	logic                 ovf_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s2_valid_s2 <= 1'b0;
		end else begin
			s2_valid_s2 <= (s1_go && last_s1) || (s2_valid_s2 && !out_free);
		end
	end

	always_ff @(posedge clk) begin
		if (s1_go && last_s1) begin
			int_s2  <= int_u;
			frac_s2 <= frac_u[WW-1:GUARD_BITS];  // drop guard bits
			neg_s2  <= neg_u;
			ok_s2   <= dig_u && !bad_u;
			ovf_s2  <= ovf_u;
		end
	end

	// result formatting
	logic [MW-1:0]      mag;
	logic [VALUE_W-1:0] mag_ext;
	logic [VALUE_W-1:0] val;
	logic [CW-1:0]      int_cmp;
	logic [CW-1:0]      lim_cmp;
	logic               lim_ok;

	assign mag      = {int_s2, frac_s2};
	assign mag_ext  = VALUE_W'(mag);
	// minus zero negates to zero
	assign val      = neg_s2 ? (VALUE_W'(0) - mag_ext) : mag_ext;
	assign int_cmp  = CW'(int_s2);
	assign lim_cmp  = CW'(range_q);
	assign lim_ok   = !ovf_s2 &&
		((int_cmp < lim_cmp) || ((int_cmp == lim_cmp) && (frac_s2 == '0)));

	// output register
	logic [DATA_W-1:0]  out_data_q;
	logic [TUSER_W-1:0] out_user_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= s2_go || (out_valid_q && !m_axis_tready);
		end
	end

	always_ff @(posedge clk) begin
		if (s2_go) begin
			out_data_q             <= DATA_W'(val);
			out_user_q[TU_VALID]   <= ok_s2;
			out_user_q[TU_INRANGE] <= lim_ok;
			out_user_q[TU_SAT]     <= ovf_s2;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tdata  = out_data_q;
	assign m_axis_tuser  = out_user_q;

endmodule

// File: design/dtfp_checker.sv
module dtfp_checker #(
	parameter int INT_BITS  = dtfp_pkg::DEF_INT_BITS,
	parameter int FRAC_BITS = dtfp_pkg::DEF_FRAC_BITS,
	localparam int VALUE_W  = INT_BITS + FRAC_BITS + 1,
	localparam int DATA_W   = ((VALUE_W + 7) / 8) * 8
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          m_axis_tvalid,
	input logic                          m_axis_tready,
	input logic [DATA_W-1:0]             m_axis_tdata,
	input logic [dtfp_pkg::TUSER_W-1:0]  m_axis_tuser
);
	import dtfp_pkg::*;

	// no result shows up right out of reset
	a_reset_idle: assert property (@(posedge clk)
		$rose(arst_n) |-> !m_axis_tvalid)
		else $error("result valid at reset release");

	// a held-back result keeps its contents
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
		else $error("stalled result changed");

	// an overflowed integer part is never in range
	a_sat_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TU_SAT] |-> !m_axis_tuser[TU_INRANGE])
		else $error("saturated result flagged in range");

	// a clamped positive value has an all-ones integer part
	a_sat_clamp: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser[TU_SAT] && !m_axis_tdata[VALUE_W-1] |->
			(&m_axis_tdata[VALUE_W-2:FRAC_BITS]))
		else $error("saturated value not clamped");

endmodule

bind decimal_text_to_fixed_point dtfp_checker #(
	.INT_BITS  (INT_BITS),
	.FRAC_BITS (FRAC_BITS)
) u_dtfp_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);
